>>> rtl/gtpu_pkg.sv
// gtpu_pkg: shared types and codes for the guest trap and privilege unit
// no dependencies; imported by every module under rtl

package gtpu_pkg;

  // operation codes carried in the opcode field
  typedef enum logic [1:0] {
    OP_EXCEPTION = 2'd0,
    OP_DEFER     = 2'd1,
    OP_XRET      = 2'd2,
    OP_SATP      = 2'd3
  } opcode_e;

  // privilege levels
  typedef enum logic [1:0] {
    PRIV_USER    = 2'd0,
    PRIV_SUPER   = 2'd1,
    PRIV_HYPER   = 2'd2,
    PRIV_MACHINE = 2'd3
  } priv_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_DEFER_FULL = 3'd1,
    ST_XRET_USER  = 3'd2,
    ST_XRET_UP    = 3'd3,
    ST_XRET_HYPER = 3'd4,
    ST_BAD_PAGING = 3'd5
  } status_e;

  // page-table switch report
  typedef enum logic [1:0] {
    SW_NONE   = 2'd0,
    SW_SHADOW = 2'd1,
    SW_ROOT   = 2'd2
  } switch_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_EXC_DELEG = 3'd0,
    CFG_IRQ_DELEG = 3'd1,
    CFG_M_VECTOR  = 3'd2,
    CFG_S_VECTOR  = 3'd3,
    CFG_MPP       = 3'd4,
    CFG_SPP       = 3'd5,
    CFG_PAGING    = 3'd6
  } cfg_idx_e;

  localparam int unsigned CauseAsyncBit = 63;
  localparam logic [3:0]  PagingBare    = 4'd0;
  localparam logic [3:0]  PagingSv39    = 4'd8;

  // input beat
  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] trap_cause;
    logic [63:0] trap_pc;
    logic [63:0] trap_value;
  } in_t;

  // result beat
  typedef struct packed {
    logic [63:0] next_pc;
    logic        next_pc_valid;
    logic [2:0]  status;
    logic [1:0]  table_switch;
    logic [1:0]  mode_now;
    logic        trap_taken;
  } out_t;

  // configuration register file contents
  typedef struct packed {
    logic [63:0] exc_delegation;
    logic [63:0] irq_delegation;
    logic [63:0] machine_vector;
    logic [63:0] super_vector;
    logic [1:0]  machine_prev_mode;
    logic        super_prev_mode;
    logic [3:0]  paging_mode;
  } cfg_t;

  // architectural trap state of the hart
  typedef struct packed {
    logic [1:0]  priv_mode;
    logic        m_int_enable;
    logic        m_prev_int_enable;
    logic        s_int_enable;
    logic        s_prev_int_enable;
    logic        m_double_trap;
    logic [63:0] m_epc;
    logic [63:0] s_epc;
    logic [63:0] m_cause;
    logic [63:0] m_tval;
    logic [63:0] s_cause;
    logic [63:0] s_tval;
    logic        pending_flag;
    logic [63:0] pending_cause;
    logic        shadow_active;
  } state_t;

endpackage

>>> rtl/guest_trap_privilege_unit.sv
// guest_trap_privilege_unit: top level with input register, state and result register
// depends on gtpu_pkg, gtpu_cfg_regs and gtpu_trap_logic

// Trap entry and xRET unit for one virtualized hart. Each input beat is one
// operation (exception, deferred exception, xRET or satp-write notice) and
// yields exactly one result beat. A beat is held in the input register, is
// resolved by a single pass of combinational logic against the trap state
// and lands in the result register once that register is free or draining,
// and a new beat is taken every cycle while the result side drains. The trap
// state is updated in the same cycle the result is loaded, which is what lets
// the next beat follow without a gap. Configuration writes are taken every
// cycle and must only be issued while the unit is idle.

module guest_trap_privilege_unit import gtpu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // operation channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  // configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  // trap state after reset: machine mode, everything else clear
  localparam state_t StateReset = '{priv_mode: PRIV_MACHINE, default: '0};

  cfg_t   cfg;
  state_t state_q, state_d;
  out_t   res;
  logic   in_valid_q;
  in_t    in_q;
  logic   out_valid_q;
  out_t   out_q;
  logic   advance;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  gtpu_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // a beat moves to the result register when that register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // operation logic
  gtpu_trap_logic u_logic (
    .op_i    (in_q),
    .cfg_i   (cfg),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res)
  );

  // trap state, committed with the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/gtpu_cfg_regs.sv
// gtpu_cfg_regs: configuration register file written over the cfg channel
// depends on gtpu_pkg

module gtpu_cfg_regs import gtpu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_en_i,
  input  logic [2:0]  wr_index_i,
  input  logic [63:0] wr_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  // decode a write beat; indexes past the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        CFG_EXC_DELEG: cfg_d.exc_delegation    = wr_data_i;
        CFG_IRQ_DELEG: cfg_d.irq_delegation    = wr_data_i;
        CFG_M_VECTOR:  cfg_d.machine_vector    = wr_data_i;
        CFG_S_VECTOR:  cfg_d.super_vector      = wr_data_i;
        CFG_MPP:       cfg_d.machine_prev_mode = wr_data_i[1:0];
        CFG_SPP:       cfg_d.super_prev_mode   = wr_data_i[0];
        CFG_PAGING:    cfg_d.paging_mode       = wr_data_i[3:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/gtpu_trap_logic.sv
// gtpu_trap_logic: single-pass next-state and result logic for one operation
// depends on gtpu_pkg

module gtpu_trap_logic import gtpu_pkg::*; (
  input  in_t    op_i,
  input  cfg_t   cfg_i,
  input  state_t state_i,
  output state_t state_o,
  output out_t   res_o
);

  // trap entry: delegate to supervisor or take to machine mode
  function automatic void enter_trap(inout state_t s, inout out_t r, input cfg_t c,
                                     input logic [63:0] cause, input logic [63:0] pc,
                                     input logic [63:0] tval);
    logic [63:0] deleg;
    logic        deleg_hit;
    deleg     = cause[CauseAsyncBit] ? c.irq_delegation : c.exc_delegation;
    deleg_hit = deleg[cause[5:0]];
    if (deleg_hit && (s.priv_mode != PRIV_MACHINE) && s.s_int_enable) begin
      s.s_prev_int_enable = s.s_int_enable;
      s.s_int_enable      = 1'b0;
      s.s_epc             = pc;
      s.s_cause           = cause;
      s.s_tval            = tval;
      s.priv_mode         = PRIV_SUPER;
      r.next_pc           = c.super_vector;
    end else begin
      if (s.shadow_active) begin
        s.shadow_active = 1'b0;
        r.table_switch  = SW_ROOT;
      end
      s.m_double_trap     = 1'b1;
      s.m_prev_int_enable = s.m_int_enable;
      s.m_int_enable      = 1'b0;
      s.m_epc             = pc;
      s.m_cause           = cause;
      s.m_tval            = tval;
      s.priv_mode         = PRIV_MACHINE;
      r.next_pc           = c.machine_vector;
    end
    r.next_pc_valid = 1'b1;
    r.trap_taken    = 1'b1;
  endfunction

  // take the deferred exception once machine interrupts are open and no double trap is marked
  function automatic void check_pending(inout state_t s, inout out_t r, input cfg_t c,
                                        input logic [63:0] pc, input logic [63:0] tval);
    if (s.m_int_enable && !s.m_double_trap && s.pending_flag) begin
      s.pending_flag = 1'b0;
      enter_trap(s, r, c, s.pending_cause, pc, tval);
    end
  endfunction

  // guest paging mode check on a drop out of machine mode or a satp write outside machine mode
  function automatic void apply_paging(inout state_t s, inout out_t r, input cfg_t c);
    if (c.paging_mode == PagingSv39) begin
      s.shadow_active = 1'b1;
      r.table_switch  = SW_SHADOW;
    end else if (c.paging_mode != PagingBare) begin
      r.status = ST_BAD_PAGING;
    end
  endfunction

  state_t      st;
  out_t        res;
  logic [1:0]  src;
  logic [1:0]  tgt;

  always_comb begin
    st  = state_i;
    res = '0;
    src = state_i.priv_mode;
    tgt = cfg_i.machine_prev_mode;
    case (op_i.opcode)
      OP_EXCEPTION: begin
        enter_trap(st, res, cfg_i, op_i.trap_cause, op_i.trap_pc, op_i.trap_value);
      end
      OP_DEFER: begin
        if (st.pending_flag) begin
          res.status = ST_DEFER_FULL;
        end else begin
          st.pending_flag  = 1'b1;
          st.pending_cause = op_i.trap_cause;
          check_pending(st, res, cfg_i, op_i.trap_pc, op_i.trap_value);
        end
      end
      OP_XRET: begin
        if (src == PRIV_SUPER) begin
          tgt = cfg_i.super_prev_mode ? PRIV_SUPER : PRIV_USER;
        end
        if (src == PRIV_USER) begin
          res.status = ST_XRET_USER;
        end else if (tgt > src) begin
          res.status = ST_XRET_UP;
        end else if (tgt == PRIV_HYPER) begin
          res.status = ST_XRET_HYPER;
        end else begin
          st.priv_mode      = tgt;
          res.next_pc       = (src == PRIV_MACHINE) ? state_i.m_epc : state_i.s_epc;
          res.next_pc_valid = 1'b1;
          if (src == PRIV_MACHINE && tgt != PRIV_MACHINE) begin
            st.m_double_trap = 1'b0;
            apply_paging(st, res, cfg_i);
          end
          // pop the interrupt-enable stack of the mode being left
          if (src == PRIV_MACHINE) begin
            st.m_int_enable      = st.m_prev_int_enable;
            st.m_prev_int_enable = 1'b1;
          end else begin
            st.s_int_enable      = st.s_prev_int_enable;
            st.s_prev_int_enable = 1'b1;
          end
          check_pending(st, res, cfg_i, res.next_pc, op_i.trap_value);
        end
      end
      OP_SATP: begin
        if (st.priv_mode != PRIV_MACHINE) begin
          apply_paging(st, res, cfg_i);
        end
      end
      default: begin
        st = state_i;
      end
    endcase
    if (!res.next_pc_valid) begin
      res.next_pc = '0;
    end
    res.mode_now = st.priv_mode;
  end

  assign state_o = st;
  assign res_o   = res;

endmodule
